// File: src/clustering_nmi_scorer_top_defines.svh
// Assertion macros shared by the checker of the NMI scorer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CLUSTERING_NMI_SCORER_TOP_DEFINES_SVH
`define CLUSTERING_NMI_SCORER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNMI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define CNMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// File: src/cnmi_pkg.sv
// Shared types and constants of the NMI clustering scorer.
// Depends on nothing; imported by every module of the block.
package cnmi_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_RD,
        ST_EVAL,
        ST_WAIT_CELL,
        ST_ROW,
        ST_WAIT_ROW,
        ST_NEXT,
        ST_TN,
        ST_WAIT_TN,
        ST_DIFF,
        ST_FORM,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_NORM,
        TS_SQ,
        TS_MUL,
        TS_DONE
    } term_state_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic REG_TRUTH = 1'b0;
    localparam logic REG_PRED  = 1'b1;

    localparam int LOG_STEPS = 24;
    localparam int DIV_STEPS = 16;
    localparam logic [16:0] NMI_ONE = 17'h10000;

endpackage

// File: src/clustering_nmi_scorer_top.sv
// Top level of the NMI clustering scorer: histogram memories and set-end sequencer.
// Depends on cnmi_pkg and cnmi_term.
//
// While busy is low the block takes one label pair per clock cycle; a pair is
// counted by a read-modify-write of the joint and predicted histogram memories,
// with forwarding between neighboring transactions. The pair marked last raises
// busy until its result strobe: the sequencer then scans MAX_PRED predicted
// entries and MAX_TRUTH*MAX_PRED joint entries, reading and zeroing every
// entry; ground-truth counts are row sums of the joint table. Each nonzero
// count in use, each nonzero row sum and the sample count go through one
// shared log unit, and a 16-step divider ends the set. After reset the same
// scan clears both memories, with busy high. Configuration writes are taken
// at any time and must only be issued while busy is low.
module clustering_nmi_scorer_top
    import cnmi_pkg::*;
#(
    parameter int MAX_TRUTH  = 64,
    parameter int MAX_PRED   = 64,
    parameter int COUNT_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [6:0]  truth_label,
    input  logic [5:0]  pred_label,
    input  logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        result_valid,
    output logic [16:0] nmi_q16,
    output logic [1:0]  status,
    output logic [19:0] sample_total
);

    localparam int CW     = COUNT_BITS;
    localparam int TI_W   = $clog2(MAX_TRUTH);
    localparam int PI_W   = $clog2(MAX_PRED);
    localparam int JDEPTH = MAX_TRUTH * MAX_PRED;
    localparam int JA_W   = $clog2(JDEPTH);
    localparam int TERM_W = CW + 21;
    localparam int SUM_W  = CW + 24;
    localparam int NW     = CW + 27;
    localparam logic [CW-1:0] CNT_MAX = '1;

    state_t state_reg, state_next;

    logic [6:0] num_truth_reg, num_pred_reg;
    logic [8:0] g_eff, p_eff;

    logic [CW-1:0] jmem [JDEPTH];
    logic [CW-1:0] pmem [MAX_PRED];
    logic j_re, j_we, p_re, p_we;
    logic [JA_W-1:0] j_raddr, j_waddr;
    logic [PI_W-1:0] p_raddr, p_waddr;
    logic [CW-1:0] j_wdata, p_wdata, j_rdata_reg, p_rdata_reg;

    logic accept, ovf, label_ok;
    logic [8:0] t9, ti9, pl9;
    logic [TI_W-1:0] ti_idx;
    logic [PI_W-1:0] pl_idx;
    logic [JA_W-1:0] ja_in;

    logic [CW-1:0] samples_reg, samples_next;
    logic [1:0] err_reg, err_next;

    logic ld_valid_reg, ld_valid_next;
    logic [JA_W-1:0] ld_ja_reg;
    logic [PI_W-1:0] ld_pa_reg;
    logic fw_valid_reg;
    logic [JA_W-1:0] fw_ja_reg;
    logic [PI_W-1:0] fw_pa_reg;
    logic [CW-1:0] fw_jd_reg, fw_pd_reg;
    logic [CW-1:0] j_cur, p_cur, j_inc, p_inc;

    logic compute_reg, compute_next;
    logic phase_reg, phase_next;
    logic [PI_W-1:0] pidx_reg, pidx_next;
    logic [TI_W-1:0] row_reg, row_next;
    logic [JA_W-1:0] jaddr_reg, jaddr_next;
    logic [CW-1:0] rowsum_reg, rowsum_next;
    logic [CW-1:0] scan_data;
    logic last_col, last_row, cell_use, row_use;

    logic [SUM_W-1:0] sg_reg, sg_next, sp_reg, sp_next, sj_reg, sj_next;
    logic [TERM_W-1:0] tn_reg, tn_next;
    logic signed [NW-1:0] tn_x, sg_x, sp_x, sj_x;
    logic signed [NW-1:0] d_reg, d_next, num_reg, num_next, den_reg, den_next;
    logic [NW-1:0] r_reg, r_next, r2, den_u;
    logic [15:0] q_reg, q_next;
    logic [3:0] div_cnt_reg, div_cnt_next;
    logic [16:0] nmi_reg, nmi_next;
    logic [1:0] status_reg, status_next;

    logic term_start, term_done;
    logic [CW-1:0] term_count;
    logic [TERM_W-1:0] term_val;

    cnmi_term #(
        .COUNT_BITS(COUNT_BITS)
    ) u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .start (term_start),
        .count (term_count),
        .done  (term_done),
        .term  (term_val)
    );

    assign g_eff = (9'(num_truth_reg) < 9'(MAX_TRUTH)) ? 9'(num_truth_reg) : 9'(MAX_TRUTH);
    assign p_eff = (9'(num_pred_reg) < 9'(MAX_PRED)) ? 9'(num_pred_reg) : 9'(MAX_PRED);

    assign accept = start && !busy;
    assign ovf = (samples_reg == CNT_MAX);
    assign t9 = 9'(truth_label);
    assign ti9 = t9 - 9'd1;
    assign pl9 = 9'(pred_label);
    assign ti_idx = ti9[TI_W-1:0];
    assign pl_idx = pl9[PI_W-1:0];
    assign label_ok = (t9 != 9'd0) && (t9 <= g_eff) && (pl9 < p_eff);
    assign ja_in = JA_W'(32'(ti_idx) * 32'(MAX_PRED) + 32'(pl_idx));

    assign j_cur = (fw_valid_reg && fw_ja_reg == ld_ja_reg) ? fw_jd_reg : j_rdata_reg;
    assign p_cur = (fw_valid_reg && fw_pa_reg == ld_pa_reg) ? fw_pd_reg : p_rdata_reg;
    assign j_inc = j_cur + CW'(1);
    assign p_inc = p_cur + CW'(1);

    assign scan_data = phase_reg ? j_rdata_reg : p_rdata_reg;
    assign last_col = (pidx_reg == PI_W'(MAX_PRED - 1));
    assign last_row = (row_reg == TI_W'(MAX_TRUTH - 1));
    assign cell_use = compute_reg && (scan_data != '0) && (9'(pidx_reg) < p_eff)
                      && (!phase_reg || 9'(row_reg) < g_eff);
    assign row_use = compute_reg && (rowsum_reg != '0) && (9'(row_reg) < g_eff);

    assign tn_x = NW'(tn_reg);
    assign sg_x = NW'(sg_reg);
    assign sp_x = NW'(sp_reg);
    assign sj_x = NW'(sj_reg);
    assign den_u = den_reg;
    assign r2 = {r_reg[NW-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (j_we)
        begin
            jmem[j_waddr] <= j_wdata;
        end
        if (j_re)
        begin
            j_rdata_reg <= jmem[j_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        if (p_re)
        begin
            p_rdata_reg <= pmem[p_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_RD;
            ST_RD:    state_next = ST_EVAL;
            ST_EVAL:  state_next = cell_use ? ST_WAIT_CELL : ST_ROW;
            ST_WAIT_CELL:
            begin
                if (term_done)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (phase_reg && last_col && row_use)
                begin
                    state_next = ST_WAIT_ROW;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_WAIT_ROW:
            begin
                if (term_done)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (phase_reg && last_col && last_row)
                begin
                    state_next = compute_reg ? ST_TN : ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_TN: state_next = ST_WAIT_TN;
            ST_WAIT_TN:
            begin
                if (term_done)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: state_next = ST_FORM;
            ST_FORM: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (err_reg == STATUS_OK && !den_reg[NW-1] && den_reg != '0
                    && !num_reg[NW-1] && num_reg != '0 && num_reg < den_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        j_re = 1'b0;
        j_raddr = jaddr_reg;
        j_we = 1'b0;
        j_waddr = jaddr_reg;
        j_wdata = '0;
        p_re = 1'b0;
        p_raddr = pidx_reg;
        p_we = 1'b0;
        p_waddr = pidx_reg;
        p_wdata = '0;
        term_start = 1'b0;
        term_count = scan_data;
        if (state_reg == ST_IDLE && accept)
        begin
            j_re = 1'b1;
            j_raddr = ja_in;
            p_re = 1'b1;
            p_raddr = pl_idx;
        end
        if (ld_valid_reg)
        begin
            j_we = 1'b1;
            j_waddr = ld_ja_reg;
            j_wdata = j_inc;
            p_we = 1'b1;
            p_waddr = ld_pa_reg;
            p_wdata = p_inc;
        end
        case (state_reg)
            ST_RD:
            begin
                j_re = phase_reg;
                p_re = !phase_reg;
            end
            ST_EVAL:
            begin
                j_we = phase_reg;
                p_we = !phase_reg;
                term_start = cell_use;
            end
            ST_ROW:
            begin
                term_count = rowsum_reg;
                term_start = phase_reg && last_col && row_use;
            end
            ST_TN:
            begin
                term_count = samples_reg;
                term_start = 1'b1;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = (state_reg == ST_OUT);
    assign nmi_q16 = nmi_reg;
    assign status = status_reg;
    assign sample_total = 20'(samples_reg);

    always_comb
    begin
        samples_next = samples_reg;
        err_next = err_reg;
        ld_valid_next = 1'b0;
        compute_next = compute_reg;
        phase_next = phase_reg;
        pidx_next = pidx_reg;
        row_next = row_reg;
        jaddr_next = jaddr_reg;
        rowsum_next = rowsum_reg;
        sg_next = sg_reg;
        sp_next = sp_reg;
        sj_next = sj_reg;
        tn_next = tn_reg;
        d_next = d_reg;
        num_next = num_reg;
        den_next = den_reg;
        r_next = r_reg;
        q_next = q_reg;
        div_cnt_next = div_cnt_reg;
        nmi_next = nmi_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (ovf)
                    begin
                        err_next = STATUS_OVERFLOW;
                    end
                    else if (!label_ok)
                    begin
                        err_next = (err_reg == STATUS_OVERFLOW) ? STATUS_OVERFLOW
                                                                : STATUS_RANGE;
                    end
                    else
                    begin
                        ld_valid_next = 1'b1;
                        samples_next = samples_reg + CW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                compute_next = 1'b1;
                phase_next = 1'b0;
                pidx_next = '0;
                row_next = '0;
                jaddr_next = '0;
                rowsum_next = '0;
                sg_next = '0;
                sp_next = '0;
                sj_next = '0;
            end
            ST_EVAL:
            begin
                if (phase_reg)
                begin
                    rowsum_next = rowsum_reg + scan_data;
                end
            end
            ST_WAIT_CELL:
            begin
                if (term_done)
                begin
                    if (phase_reg)
                    begin
                        sj_next = sj_reg + SUM_W'(term_val);
                    end
                    else
                    begin
                        sp_next = sp_reg + SUM_W'(term_val);
                    end
                end
            end
            ST_WAIT_ROW:
            begin
                if (term_done)
                begin
                    sg_next = sg_reg + SUM_W'(term_val);
                end
            end
            ST_NEXT:
            begin
                if (!phase_reg)
                begin
                    if (last_col)
                    begin
                        phase_next = 1'b1;
                        pidx_next = '0;
                        row_next = '0;
                        jaddr_next = '0;
                        rowsum_next = '0;
                    end
                    else
                    begin
                        pidx_next = pidx_reg + PI_W'(1);
                    end
                end
                else
                begin
                    jaddr_next = jaddr_reg + JA_W'(1);
                    if (last_col)
                    begin
                        pidx_next = '0;
                        row_next = row_reg + TI_W'(1);
                        rowsum_next = '0;
                    end
                    else
                    begin
                        pidx_next = pidx_reg + PI_W'(1);
                    end
                end
            end
            ST_WAIT_TN:
            begin
                if (term_done)
                begin
                    tn_next = term_val;
                end
            end
            ST_DIFF: d_next = tn_x - sg_x - sp_x;
            ST_FORM:
            begin
                num_next = (d_reg + sj_x) <<< 1;
                den_next = d_reg + tn_x;
            end
            ST_CHECK:
            begin
                r_next = num_reg;
                q_next = '0;
                div_cnt_next = '0;
                nmi_next = '0;
                status_next = STATUS_OK;
                if (err_reg != STATUS_OK)
                begin
                    status_next = err_reg;
                end
                else if (den_reg[NW-1] || den_reg == '0)
                begin
                    status_next = STATUS_ZERO_DEN;
                end
                else if (!num_reg[NW-1] && num_reg != '0 && num_reg >= den_reg)
                begin
                    nmi_next = NMI_ONE;
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 4'd1;
                if (r2 >= den_u)
                begin
                    r_next = r2 - den_u;
                    q_next = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    r_next = r2;
                    q_next = {q_reg[14:0], 1'b0};
                end
                nmi_next = {1'b0, q_next};
            end
            ST_OUT:
            begin
                samples_next = '0;
                err_next = STATUS_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RD;
            num_truth_reg <= 7'd64;
            num_pred_reg <= 7'd64;
            samples_reg <= '0;
            err_reg <= STATUS_OK;
            ld_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            compute_reg <= 1'b0;
            phase_reg <= 1'b0;
            pidx_reg <= '0;
            row_reg <= '0;
            jaddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TRUTH)
                begin
                    num_truth_reg <= cfg_data;
                end
                if (cfg_index == REG_PRED)
                begin
                    num_pred_reg <= cfg_data;
                end
            end
            samples_reg <= samples_next;
            err_reg <= err_next;
            ld_valid_reg <= ld_valid_next;
            fw_valid_reg <= ld_valid_reg;
            compute_reg <= compute_next;
            phase_reg <= phase_next;
            pidx_reg <= pidx_next;
            row_reg <= row_next;
            jaddr_reg <= jaddr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_ja_reg <= ja_in;
        ld_pa_reg <= pl_idx;
        fw_ja_reg <= ld_ja_reg;
        fw_pa_reg <= ld_pa_reg;
        fw_jd_reg <= j_inc;
        fw_pd_reg <= p_inc;
        rowsum_reg <= rowsum_next;
        sg_reg <= sg_next;
        sp_reg <= sp_next;
        sj_reg <= sj_next;
        tn_reg <= tn_next;
        d_reg <= d_next;
        num_reg <= num_next;
        den_reg <= den_next;
        r_reg <= r_next;
        q_reg <= q_next;
        div_cnt_reg <= div_cnt_next;
        nmi_reg <= nmi_next;
        status_reg <= status_next;
    end

endmodule

// File: src/cnmi_term.sv
// Iterative unit for one entropy term c*log2(c) rounded to 16 fractional bits.
// Depends on cnmi_pkg; instantiated by clustering_nmi_scorer_top.
module cnmi_term
    import cnmi_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COUNT_BITS-1:0]   count,
    output logic                    done,
    output logic [COUNT_BITS+20:0]  term
);

    localparam int PROD_W = COUNT_BITS + 29;

    term_state_t state_reg, state_next;
    logic [30:0] m_reg, m_next;
    logic [4:0] e_reg, e_next;
    logic [23:0] frac_reg, frac_next;
    logic [4:0] step_reg, step_next;
    logic [COUNT_BITS-1:0] c_reg, c_next;
    logic [COUNT_BITS+20:0] term_reg, term_next;

    logic [31:0] c32;
    logic [61:0] sq;
    logic [31:0] sq_hi;
    logic [28:0] lval;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rounded;

    assign c32 = 32'(count);
    assign sq = 62'(m_reg) * 62'(m_reg);
    assign sq_hi = sq[61:30];
    assign lval = {e_reg, frac_reg};
    assign prod = PROD_W'(c_reg) * PROD_W'(lval);
    assign rounded = prod + PROD_W'(128);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (start)
                begin
                    state_next = TS_NORM;
                end
            end
            TS_NORM:
            begin
                if (m_reg[30] || e_reg == 5'd0)
                begin
                    state_next = TS_SQ;
                end
            end
            TS_SQ:
            begin
                if (step_reg == 5'(LOG_STEPS - 1))
                begin
                    state_next = TS_MUL;
                end
            end
            TS_MUL:  state_next = TS_DONE;
            TS_DONE: state_next = TS_IDLE;
            default: state_next = TS_IDLE;
        endcase
    end

    always_comb
    begin
        m_next = m_reg;
        e_next = e_reg;
        frac_next = frac_reg;
        step_next = step_reg;
        c_next = c_reg;
        term_next = term_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (start)
                begin
                    c_next = count;
                    frac_next = '0;
                    step_next = '0;
                    if (c32[31])
                    begin
                        m_next = c32[31:1];
                        e_next = 5'd31;
                    end
                    else
                    begin
                        m_next = c32[30:0];
                        e_next = 5'd30;
                    end
                end
            end
            TS_NORM:
            begin
                if (!m_reg[30] && e_reg != 5'd0)
                begin
                    m_next = {m_reg[29:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            TS_SQ:
            begin
                step_next = step_reg + 5'd1;
                if (sq_hi[31])
                begin
                    m_next = sq_hi[31:1];
                    frac_next = {frac_reg[22:0], 1'b1};
                end
                else
                begin
                    m_next = sq_hi[30:0];
                    frac_next = {frac_reg[22:0], 1'b0};
                end
            end
            TS_MUL:  term_next = rounded[PROD_W-1:8];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        e_reg <= e_next;
        frac_reg <= frac_next;
        step_reg <= step_next;
        c_reg <= c_next;
        term_reg <= term_next;
    end

    assign done = (state_reg == TS_DONE);
    assign term = term_reg;

endmodule

// File: src/cnmi_checker.sv
// Port-level checker of the NMI scorer and its bind to the top level.
// Depends on cnmi_pkg and clustering_nmi_scorer_top_defines.svh.
`include "clustering_nmi_scorer_top_defines.svh"

module cnmi_checker
    import cnmi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last,
    input logic        result_valid,
    input logic [16:0] nmi_q16,
    input logic [1:0]  status
);

    `CNMI_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid)
    `CNMI_ASSERT_SAME(a_strobe_busy, clk, rst_n, result_valid, busy)
    `CNMI_ASSERT_NEXT(a_plain_item_ready, clk, rst_n, start && !busy && !last, !busy)
    `CNMI_ASSERT_NEXT(a_last_item_busy, clk, rst_n, start && !busy && last, busy)
    `CNMI_ASSERT_SAME(a_error_zero, clk, rst_n, result_valid && status != STATUS_OK, nmi_q16 == 17'd0)

endmodule

bind clustering_nmi_scorer_top cnmi_checker u_cnmi_checker (.*);
